[rtl/watchpoint_range_matcher_assert.svh]
// ----------------------------------------------------------------------------
// Watchpoint range matcher: assertion macros
// Shared property forms for the checker, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WATCHPOINT_RANGE_MATCHER_ASSERT_SVH
`define WATCHPOINT_RANGE_MATCHER_ASSERT_SVH

// same-cycle implication
`define WRM_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchpoint range matcher: property failed");

// next-cycle implication
`define WRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchpoint range matcher: property failed");

`endif

[rtl/wrm_pkg.sv]
// ----------------------------------------------------------------------------
// wrm_pkg
// Types, codes and defaults shared by the watchpoint range matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wrm_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int HIT_BITS_DEFAULT = 16;

    // command codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    // access kinds
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_ACCESS = 2'd3;

    // response status
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [31:0] range_length;
        logic [1:0]  kind;
    } wrm_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  hit_index;
        logic [15:0] hit_total;
    } wrm_rsp_t;

    // one stored watchpoint, less its hit count
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
        logic [1:0]  kind;
    } wrm_entry_t;

    // per-cell strobes from the sequencer
    typedef struct packed {
        logic capture;  // register compare flags against the incoming word
        logic load;     // write a new entry
        logic shift;    // take the upper neighbor's entry
        logic bump;     // count a hit
    } wrm_ctrl_t;

endpackage

`default_nettype wire

[rtl/wrm_cell.sv]
// ----------------------------------------------------------------------------
// wrm_cell
// One table slot: entry storage, hit counter, range/kind and base compares.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_cell
    import wrm_pkg::*;
#(
    parameter int HIT_BITS = HIT_BITS_DEFAULT
)
(
    input  logic                clk,
    input  wrm_ctrl_t           ctrl,
    input  wrm_cmd_t            probe,
    input  wrm_entry_t          fill,
    input  wrm_entry_t          nbr,
    input  logic [HIT_BITS-1:0] nbr_hits,
    output wrm_entry_t          entry,
    output logic [HIT_BITS-1:0] hits,
    output logic                match,
    output logic                same
);

    wrm_entry_t          entry_reg;
    logic [HIT_BITS-1:0] hits_reg;
    logic                match_reg;
    logic                same_reg;
    logic                match_next;
    logic                same_next;
    logic [32:0]         range_end;
    logic                kind_hit;

    // end computed at 33 bits, no wrap
    assign range_end = {1'b0, entry_reg.base} + {1'b0, entry_reg.length};
    assign kind_hit  = ((probe.kind == KIND_WRITE) || (probe.kind == KIND_READ))
                       && ((entry_reg.kind & probe.kind) != 2'b00);

    assign match_next = (probe.address >= entry_reg.base)
                        && ({1'b0, probe.address} < range_end) && kind_hit;
    assign same_next  = (probe.address == entry_reg.base);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= fill;
            hits_reg  <= '0;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= nbr;
            hits_reg  <= nbr_hits;
        end
        else if (ctrl.bump && !(&hits_reg))
        begin
            hits_reg <= hits_reg + 1'b1;
        end

        if (ctrl.capture)
        begin
            match_reg <= match_next;
            same_reg  <= same_next;
        end
    end

    assign entry = entry_reg;
    assign hits  = hits_reg;
    assign match = match_reg;
    assign same  = same_reg;

endmodule

`default_nettype wire

[rtl/wrm_pick.sv]
// ----------------------------------------------------------------------------
// wrm_pick
// Lowest-set priority pick over the cell flags: one-hot, mask below, index.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_pick
    import wrm_pkg::*;
#(
    parameter int N     = DEPTH_DEFAULT,
    parameter int IDX_W = 4
)
(
    input  logic [N-1:0]     req,
    output logic [N-1:0]     first,
    output logic [N-1:0]     below,
    output logic [IDX_W-1:0] index,
    output logic             any
);

    assign first = req & (~req + 1'b1);
    assign below = first - 1'b1;
    assign any   = |req;

    always_comb
    begin
        index = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/watchpoint_range_matcher.sv]
// ----------------------------------------------------------------------------
// watchpoint_range_matcher
// Compacted watchpoint table built as a chain of slot cells, with add,
// remove-and-compact and first-match check with saturating hit counts.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+----------------------------------
//   cmd     | in  | cmd_valid/cmd_stall  | op, address, range_length, kind
//   rsp     | out | rsp_valid/rsp_stall  | status, hit, hit_index, hit_total
//
// Each command goes through an accept step and an apply step: the accept edge
// registers every cell's range and base compares, and the apply step then makes
// the update and loads the response register. cmd_stall is high while a command is in flight.
// A waiting response does not block a new command; the apply step holds only
// if the response register is still occupied.
// Reset clears the entry count; slot contents stay undefined and are never
// read before an add writes them, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module watchpoint_range_matcher
    import wrm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int HIT_BITS    = HIT_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  wrm_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output wrm_rsp_t rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // sequencing
    logic             pend_reg;
    logic             pend_next;
    wrm_cmd_t         word_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    wrm_rsp_t         rsp_reg;
    wrm_rsp_t         rsp_next;

    logic accept;
    logic apply;
    logic is_add;
    logic is_rem;
    logic is_chk;
    logic full;

    // cell chain
    wrm_ctrl_t           ctrl      [TABLE_DEPTH];
    wrm_entry_t          entry     [TABLE_DEPTH];
    wrm_entry_t          nbr_entry [TABLE_DEPTH];
    logic [HIT_BITS-1:0] hits      [TABLE_DEPTH];
    logic [HIT_BITS-1:0] nbr_hits  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] same_vec;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] pick_vec;
    wrm_entry_t             fill;

    // pick results
    logic [TABLE_DEPTH-1:0] first;
    logic [TABLE_DEPTH-1:0] below;
    logic [IDX_W-1:0]       pick_idx;
    logic                   any;

    logic [HIT_BITS-1:0] sel_hits;
    logic [HIT_BITS-1:0] total_next;
    logic [31:0]         idx_wide;
    logic [31:0]         total_wide;

    // one command at a time; the response register decouples the output side
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = pend_reg;
    assign apply     = pend_reg && (!out_valid_reg || !rsp_stall);

    assign is_add = (word_reg.op == OP_ADD);
    assign is_rem = (word_reg.op == OP_REMOVE);
    assign is_chk = (word_reg.op == OP_CHECK);
    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));

    assign fill.base   = word_reg.address;
    assign fill.length = word_reg.range_length;
    assign fill.kind   = word_reg.kind;

    // slots below the count are live; the rest hold stale data
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_vec[i] = (CNT_W'(i) < count_reg);
        end
    end

    // remove looks for an equal base, check for a range hit
    assign pick_vec = (is_rem ? same_vec : match_vec) & valid_vec;

    // neighbor links: each slot takes from the one above; the top slot gets zero
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
            begin
                nbr_entry[i] = '0;
                nbr_hits[i]  = '0;
            end
            else
            begin
                nbr_entry[i] = entry[i + 1];
                nbr_hits[i]  = hits[i + 1];
            end
        end
    end

    // per-slot strobes: add writes at the count, remove compacts from the
    // found slot upward, check bumps only the first hit
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ctrl[i].capture = accept;
            ctrl[i].load    = apply && is_add && !full && (count_reg == CNT_W'(i));
            ctrl[i].shift   = apply && is_rem && any && !below[i];
            ctrl[i].bump    = apply && is_chk && first[i];
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        wrm_cell #(
            .HIT_BITS (HIT_BITS)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl[g]),
            .probe    (cmd),
            .fill     (fill),
            .nbr      (nbr_entry[g]),
            .nbr_hits (nbr_hits[g]),
            .entry    (entry[g]),
            .hits     (hits[g]),
            .match    (match_vec[g]),
            .same     (same_vec[g])
        );
    end

    wrm_pick #(
        .N     (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_pick (
        .req   (pick_vec),
        .first (first),
        .below (below),
        .index (pick_idx),
        .any   (any)
    );

    // hit count of the picked slot, as it reads before the bump
    always_comb
    begin
        sel_hits = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (first[i])
            begin
                sel_hits = sel_hits | hits[i];
            end
        end
    end

    assign total_next = (&sel_hits) ? sel_hits : sel_hits + 1'b1;
    assign idx_wide   = 32'(pick_idx);
    assign total_wide = 32'(total_next);

    // response and count update
    always_comb
    begin
        rsp_next   = '0;
        count_next = count_reg;
        case (word_reg.op)
            OP_ADD:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (any)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            OP_CHECK:
            begin
                if (any)
                begin
                    rsp_next.hit       = 1'b1;
                    rsp_next.hit_index = idx_wide[3:0];
                    rsp_next.hit_total = total_wide[15:0];
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (apply)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (apply)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= cmd;
        end
        if (apply)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/wrm_checker.sv]
// ----------------------------------------------------------------------------
// wrm_checker
// Port-level properties of the watchpoint range matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "watchpoint_range_matcher_assert.svh"

module wrm_checker
    import wrm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input wrm_rsp_t rsp
);

    // a held response keeps its word and its valid
    `WRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, $stable(rsp))
    `WRM_ASSERT_NEXT(a_rsp_keep, rsp_valid && rsp_stall, rsp_valid)

    // one command in flight: the cycle after an accept is stalled
    `WRM_ASSERT_NEXT(a_one_inflight, cmd_valid && !cmd_stall, cmd_stall)

    // no hit means cleared index and count
    `WRM_ASSERT_IMPLY(a_miss_clear, rsp_valid && !rsp.hit,
        (rsp.hit_index == 4'd0) && (rsp.hit_total == 16'd0))

    // a hit only comes with done status
    `WRM_ASSERT_IMPLY(a_hit_done, rsp_valid && rsp.hit, rsp.status == ST_DONE)

endmodule

bind watchpoint_range_matcher wrm_checker u_wrm_checker (.*);

`default_nettype wire

[verif/tb_top.sv]
// ============================================================================
// tb_top: watchpoint range matcher testbench
// Drives add, remove and check words through the valid/stall channels and
// scores every response against a cycle-free model of the watchpoint table.
// A short table of directed words comes first, then biased random traffic under
// three idling profiles with one long response hold-off, then a short burst of
// checks on one entry, after the table is emptied, so its hit count climbs word after word.
// ============================================================================

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wrm_pkg::*;

    // ------------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------------
    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS  = 440;
    localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
    localparam int HAMMER_CHECKS = 16;      // back-to-back checks on one entry
    localparam int PLAN_ROWS     = 24;

    // Codes the package has no name for
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] KIND_NONE = 2'd0;

    // ------------------------------------------------------------------------
    // DUT hookup; every input is known from time zero
    // ------------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    wrm_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    wrm_rsp_t rsp;

    watchpoint_range_matcher uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the watchpoint table. It is advanced when a word is generated,
    // not when it is accepted: words go in strictly in order, so the state the
    // generator peeks at is always exact.
    // ------------------------------------------------------------------------
    logic [31:0] wp_base [DEPTH];
    logic [31:0] wp_len  [DEPTH];
    logic [1:0]  wp_kind [DEPTH];
    logic [15:0] wp_hits [DEPTH];
    int          wp_count = 0;

    function automatic wrm_rsp_t predict_response(input wrm_cmd_t c);
        wrm_rsp_t    r;
        logic [32:0] range_end;
        bit          found;
        bit          kind_ok;
        int          i;
        int          j;
        r     = '0;
        found = 1'b0;
        case (c.op)
            OP_ADD:
            begin
                if (wp_count < DEPTH)
                begin
                    wp_base[wp_count] = c.address;
                    wp_len[wp_count]  = c.range_length;
                    wp_kind[wp_count] = c.kind;
                    wp_hits[wp_count] = '0;
                    wp_count++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                r.status = ST_MISS;
                for (i = 0; i < wp_count && !found; i++)
                begin
                    if (wp_base[i] == c.address)
                    begin
                        // close the gap: later entries slide down one slot
                        for (j = i; j + 1 < wp_count; j++)
                        begin
                            wp_base[j] = wp_base[j + 1];
                            wp_len[j]  = wp_len[j + 1];
                            wp_kind[j] = wp_kind[j + 1];
                            wp_hits[j] = wp_hits[j + 1];
                        end
                        wp_count--;
                        r.status = ST_DONE;
                        found    = 1'b1;
                    end
                end
            end
            OP_CHECK:
            begin
                for (i = 0; i < wp_count && !found; i++)
                begin
                    // 33-bit end, so a range touching the top never wraps
                    range_end = {1'b0, wp_base[i]} + {1'b0, wp_len[i]};
                    kind_ok   = (c.kind == KIND_WRITE &&
                                 (wp_kind[i] == KIND_WRITE || wp_kind[i] == KIND_ACCESS)) ||
                                (c.kind == KIND_READ &&
                                 (wp_kind[i] == KIND_READ || wp_kind[i] == KIND_ACCESS));
                    if (c.address >= wp_base[i] && {1'b0, c.address} < range_end && kind_ok)
                    begin
                        if (wp_hits[i] != '1)
                            wp_hits[i]++;
                        r.hit       = 1'b1;
                        r.hit_index = i[3:0];
                        r.hit_total = wp_hits[i];
                        found       = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused op: no state change, all-zero response
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. The response expected for the word on the cmd bus travels
    // next to it (cmd_expect) and is queued at the edge that accepts the word.
    // Everything is sampled at the rising edge, before any NBA update lands.
    // ------------------------------------------------------------------------
    wrm_rsp_t cmd_expect = '0;
    wrm_rsp_t pending_rsp_q [$];
    int       fault_count = 0;

    task automatic flag_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin : scoreboard
        wrm_rsp_t want;
        if (cmd_valid && !cmd_stall)
            pending_rsp_q.push_back(cmd_expect);
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                flag_fault("response with nothing pending", '0, 32'(rsp));
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.status !== want.status)
                    flag_fault("status", 32'(want.status), 32'(rsp.status));
                if (rsp.hit !== want.hit)
                    flag_fault("hit", 32'(want.hit), 32'(rsp.hit));
                if (rsp.hit_index !== want.hit_index)
                    flag_fault("hit_index", 32'(want.hit_index), 32'(rsp.hit_index));
                if (rsp.hit_total !== want.hit_total)
                    flag_fault("hit_total", 32'(want.hit_total), 32'(rsp.hit_total));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver side: random stall at stall_pct percent, forced high during
    // the long hold-off so the one-deep response stage backs up into cmd.
    // ------------------------------------------------------------------------
    int   stall_pct   = 0;
    logic hold_active = 1'b0;
    bit   hold_go     = 1'b0;

    always @(posedge clk)
        rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    int gap_pct = 0;

    task automatic set_idling(input int send_pct, input int recv_pct);
        gap_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    // Offer one word and return at the edge that takes it. The payload holds
    // still while stalled; valid is only dropped for an idle gap.
    task automatic send_word(input wrm_cmd_t c, input wrm_rsp_t e);
        while ($urandom_range(99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd        <= c;
        cmd_expect <= e;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Addresses: uniform, a tight cluster so bases repeat and ranges overlap,
    // and the two ends of the space.
    function automatic logic [31:0] scatter_address();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom;
        else if (sel < 80)
            return 32'h8000_0000 + ($urandom_range(15) << 6);
        else if (sel < 90)
            return 32'hFFFF_FF00 + $urandom_range(255);
        else
            return $urandom_range(255);
    endfunction

    // Mostly well-formed traffic aimed at live entries, plus some noise.
    function automatic wrm_cmd_t random_word();
        wrm_cmd_t c;
        int       sel;
        int       add_share;
        int       pick;
        c.address      = $urandom;
        c.range_length = $urandom;
        c.kind         = 2'($urandom_range(3));
        add_share      = (wp_count >= DEPTH - 2) ? 15 : (wp_count <= 2) ? 50 : 30;
        sel            = $urandom_range(99);
        if (sel < 3)
        begin
            c.op = OP_UNUSED;
        end
        else if (sel < 6)
        begin
            // check with a kind that can never match
            c.op      = OP_CHECK;
            c.address = scatter_address();
            c.kind    = sel[0] ? KIND_ACCESS : KIND_NONE;
        end
        else if (sel < 6 + add_share)
        begin
            c.op      = OP_ADD;
            c.address = scatter_address();
            sel       = $urandom_range(99);
            if (sel < 8)
                c.range_length = '0;
            else if (sel < 16)
                c.range_length = $urandom;
            else if (sel < 20)
                c.range_length = '1;
            else
                c.range_length = $urandom_range(512, 1);
            c.kind = ($urandom_range(99) < 5) ? KIND_NONE : 2'($urandom_range(3, 1));
        end
        else if (sel < 26 + add_share)
        begin
            c.op = OP_REMOVE;
            if (wp_count > 0 && $urandom_range(99) < 75)
                c.address = wp_base[$urandom_range(wp_count - 1)];
            else
                c.address = scatter_address();
        end
        else
        begin
            c.op   = OP_CHECK;
            c.kind = ($urandom_range(1) == 0) ? KIND_WRITE : KIND_READ;
            if (wp_count > 0 && $urandom_range(99) < 80)
            begin
                pick = $urandom_range(wp_count - 1);
                if ($urandom_range(99) < 10)
                    c.address = wp_base[pick] + wp_len[pick];   // one past the end
                else if (wp_len[pick] == 0)
                    c.address = wp_base[pick];
                else
                    c.address = wp_base[pick] + ($urandom % wp_len[pick]);
                if ((wp_kind[pick] == KIND_WRITE || wp_kind[pick] == KIND_READ) &&
                    $urandom_range(99) < 70)
                    c.kind = wp_kind[pick];
            end
            else
            begin
                c.address = scatter_address();
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Directed words. Rows marked typed carry a status read straight off the
    // spec (their hit fields are all zero); the rest go through the model.
    // ------------------------------------------------------------------------
    typedef struct packed {
        wrm_cmd_t   word;
        logic [4:0] reps;
        logic       typed;
        logic [1:0] status;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // empty table: check misses, remove finds nothing, unused op is inert
        '{'{OP_CHECK,  32'h0000_0000, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b1, ST_DONE},
        '{'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, KIND_NONE},   5'd1,  1'b1, ST_MISS},
        '{'{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_ACCESS}, 5'd1,  1'b1, ST_DONE},
        // whole space minus the top byte; top byte with a max length (no wrap);
        // a zero-length range; an entry with kind zero
        '{'{OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, KIND_ACCESS}, 5'd1,  1'b1, ST_DONE},
        '{'{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_WRITE},  5'd1,  1'b1, ST_DONE},
        '{'{OP_ADD,    32'h0000_1000, 32'h0000_0000, KIND_READ},   5'd1,  1'b1, ST_DONE},
        '{'{OP_ADD,    32'h0000_2000, 32'h0000_0010, KIND_NONE},   5'd1,  1'b1, ST_DONE},
        '{'{OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'hFFFF_FFFE, 32'h0000_0000, KIND_READ},   5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'h0000_0000, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b0, ST_DONE},
        // access kinds that never match
        '{'{OP_CHECK,  32'h0000_0005, 32'h0000_0000, KIND_NONE},   5'd1,  1'b1, ST_DONE},
        '{'{OP_CHECK,  32'h0000_0005, 32'h0000_0000, KIND_ACCESS}, 5'd1,  1'b1, ST_DONE},
        // drop the catch-all at slot 0 so the rest become visible
        '{'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, KIND_NONE},   5'd1,  1'b1, ST_DONE},
        '{'{OP_CHECK,  32'h0000_1000, 32'h0000_0000, KIND_READ},   5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'h0000_2005, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, KIND_READ},   5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b0, ST_DONE},
        '{'{OP_REMOVE, 32'h1234_5678, 32'h0000_0000, KIND_NONE},   5'd1,  1'b1, ST_MISS},
        // fill with duplicates of one base, then one add too many
        '{'{OP_ADD,    32'h8000_0000, 32'h0000_0100, KIND_READ},   5'd13, 1'b1, ST_DONE},
        '{'{OP_ADD,    32'h5555_5555, 32'hAAAA_AAAA, KIND_WRITE},  5'd1,  1'b1, ST_FULL},
        '{'{OP_CHECK,  32'h8000_00FF, 32'h0000_0000, KIND_READ},   5'd1,  1'b0, ST_DONE},
        '{'{OP_CHECK,  32'h8000_0100, 32'h0000_0000, KIND_READ},   5'd1,  1'b0, ST_DONE},
        // remove takes the first of the duplicates only
        '{'{OP_REMOVE, 32'h8000_0000, 32'h0000_0000, KIND_NONE},   5'd1,  1'b1, ST_DONE},
        '{'{OP_CHECK,  32'h8000_0000, 32'h0000_0000, KIND_WRITE},  5'd1,  1'b0, ST_DONE}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        wrm_cmd_t c;
        wrm_rsp_t answer;
        int       r;
        int       n;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sender light, receiver heavy
        set_idling(10, 68);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            repeat (PLAN[r].reps)
            begin
                answer = predict_response(PLAN[r].word);
                if (PLAN[r].typed)
                    answer = '{PLAN[r].status, 1'b0, 4'd0, 16'd0};
                send_word(PLAN[r].word, answer);
            end
        end

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
                set_idling(68, 10);
            else if (n == 2 * RANDOM_WORDS / 3)
                set_idling(0, 0);
            // long receiver hold-off while words keep coming
            if (n == 40)
                hold_go = 1'b1;
            c = random_word();
            send_word(c, predict_response(c));
        end

        // empty the table from the front, then hit one entry word after
        // word so its count climbs
        while (wp_count > 0)
        begin
            c = '{OP_REMOVE, wp_base[0], 32'h0, KIND_NONE};
            send_word(c, predict_response(c));
        end
        c = '{OP_ADD, 32'h4000_0000, 32'h0000_0100, KIND_ACCESS};
        send_word(c, predict_response(c));
        repeat (HAMMER_CHECKS)
        begin
            c = '{OP_CHECK, 32'h4000_0000 + $urandom_range(255), 32'h0,
                  ($urandom_range(1) == 0) ? KIND_WRITE : KIND_READ};
            send_word(c, predict_response(c));
        end
        cmd_valid <= 1'b0;

        // drain; the last word was already queued at the edge that took it
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
